// ===== design/iam_pkg.sv =====
// Shared constants and the energy width helper for the invariant mass core.
// No dependencies.
package iam_pkg;

  localparam int MASS_BITS = 23;
  localparam int OUT_BITS  = 26;
  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  // Energy root width for a given momentum width.
  function automatic int energy_width(input int mom_bits);
    return ((mom_bits > MASS_BITS) ? mom_bits : MASS_BITS) + 1;
  endfunction

endpackage

// ===== design/iam_if.sv =====
// Valid/ready channel interfaces for particle pair beats and mass beats.
// Depends on iam_pkg.
interface iam_in_if #(parameter int MOMENTUM_BITS = 24);
  import iam_pkg::*;
  logic                            valid;
  logic                            ready;
  logic [MASS_BITS-1:0]            first_mass;
  logic signed [MOMENTUM_BITS-1:0] first_px;
  logic signed [MOMENTUM_BITS-1:0] first_py;
  logic signed [MOMENTUM_BITS-1:0] first_pz;
  logic [MASS_BITS-1:0]            second_mass;
  logic signed [MOMENTUM_BITS-1:0] second_px;
  logic signed [MOMENTUM_BITS-1:0] second_py;
  logic signed [MOMENTUM_BITS-1:0] second_pz;

  modport source (output valid, first_mass, first_px, first_py, first_pz,
                  second_mass, second_px, second_py, second_pz, input ready);
  modport sink (input valid, first_mass, first_px, first_py, first_pz,
                second_mass, second_px, second_py, second_pz, output ready);
endinterface

interface iam_out_if;
  import iam_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] pair_mass;
  logic                radicand_clamped;

  modport source (output valid, pair_mass, radicand_clamped, input ready);
  modport sink (input valid, pair_mass, radicand_clamped, output ready);
endinterface

// ===== design/iam_sqrt_pipe.sv =====
// Pipelined truncated square root, one root bit per register stage.
// Carries a side payload alongside; depends on nothing else.
module iam_sqrt_pipe #(
  parameter int RW = 50,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic [RW-1:0]       in_rad,
  input  logic [SW-1:0]       in_side,
  output logic                out_v,
  output logic [RW/2-1:0]     out_root,
  output logic [SW-1:0]       out_side
);
  localparam int QW = RW / 2;
  localparam int MW = QW + 2;

  logic          v_r    [QW];
  logic [MW-1:0] rem_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [RW-1:0] rad_r  [QW];
  logic [SW-1:0] side_r [QW];

  logic          v_in    [QW];
  logic [MW-1:0] rem_in  [QW];
  logic [QW-1:0] q_in    [QW];
  logic [RW-1:0] rad_in  [QW];
  logic [SW-1:0] side_in [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [MW+1:0] cat;
    logic [MW+1:0] trial;
    logic          ge;
    logic [MW+1:0] diff;

    if (k == 0) begin : g_first
      assign v_in[k]    = in_v;
      assign rem_in[k]  = '0;
      assign q_in[k]    = '0;
      assign rad_in[k]  = in_rad;
      assign side_in[k] = in_side;
    end else begin : g_next
      assign v_in[k]    = v_r[k-1];
      assign rem_in[k]  = rem_r[k-1];
      assign q_in[k]    = q_r[k-1];
      assign rad_in[k]  = rad_r[k-1];
      assign side_in[k] = side_r[k-1];
    end

    assign cat   = {rem_in[k], rad_in[k][RW-1-2*k -: 2]};
    assign trial = {2'b00, q_in[k], 2'b01};
    assign ge    = cat >= trial;
    assign diff  = cat - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[MW-1:0] : cat[MW-1:0];
        q_r[k]    <= {q_in[k][QW-2:0], ge};
        rad_r[k]  <= rad_in[k];
        side_r[k] <= side_in[k];
      end
    end
  end

  assign out_v    = v_r[QW-1];
  assign out_root = q_r[QW-1];
  assign out_side = side_r[QW-1];
endmodule

// ===== design/iam_prep.sv =====
// Front stages: magnitudes, squares and radicand sums for both energies and
// the summed momentum. Depends on iam_pkg.
module iam_prep #(
  parameter int MB = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_v,
  input  logic [iam_pkg::MASS_BITS-1:0]  m1,
  input  logic [iam_pkg::MASS_BITS-1:0]  m2,
  input  logic signed [MB-1:0]           mom [6],
  output logic                           out_v,
  output logic [2*iam_pkg::energy_width(MB)-1:0] rad1,
  output logic [2*iam_pkg::energy_width(MB)-1:0] rad2,
  output logic [2*MB+1:0]                p2
);
  import iam_pkg::*;
  localparam int EW  = energy_width(MB);
  localparam int RW1 = 2 * EW;
  localparam int MSW = 2 * MASS_BITS;

  logic                 v0_r, v1_r, v2_r;
  logic [MASS_BITS-1:0] m1_r, m2_r;
  logic [MB-1:0]        mag_r [6];
  logic [MB:0]          smag_r [3];
  logic [MSW-1:0]       msq1_r, msq2_r;
  logic [2*MB-1:0]      psq_r [6];
  logic [2*MB+1:0]      ssq_r [3];
  logic [RW1-1:0]       rad1_r, rad2_r;
  logic [2*MB+1:0]      p2_r;

  logic [MB-1:0]        mag_nxt [6];
  logic signed [MB:0]   sum_nxt [3];
  logic [MB:0]          smag_nxt [3];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mag_nxt[i] = mom[i][MB-1] ? MB'(-mom[i]) : MB'(mom[i]);
    end
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i]  = {mom[i][MB-1], mom[i]} + {mom[i+3][MB-1], mom[i+3]};
      smag_nxt[i] = sum_nxt[i][MB] ? (MB+1)'(-sum_nxt[i]) : (MB+1)'(sum_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_v;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= m1;
      m2_r   <= m2;
      mag_r  <= mag_nxt;
      smag_r <= smag_nxt;
      msq1_r <= MSW'(m1_r) * MSW'(m1_r);
      msq2_r <= MSW'(m2_r) * MSW'(m2_r);
      for (int i = 0; i < 6; i++) begin
        psq_r[i] <= (2*MB)'(mag_r[i]) * (2*MB)'(mag_r[i]);
      end
      for (int i = 0; i < 3; i++) begin
        ssq_r[i] <= (2*MB+2)'(smag_r[i]) * (2*MB+2)'(smag_r[i]);
      end
      rad1_r <= RW1'(msq1_r) + RW1'(psq_r[0]) + RW1'(psq_r[1]) + RW1'(psq_r[2]);
      rad2_r <= RW1'(msq2_r) + RW1'(psq_r[3]) + RW1'(psq_r[4]) + RW1'(psq_r[5]);
      p2_r   <= ssq_r[0] + ssq_r[1] + ssq_r[2];
    end
  end

  assign out_v = v2_r;
  assign rad1  = rad1_r;
  assign rad2  = rad2_r;
  assign p2    = p2_r;
endmodule

// ===== design/iam_combine.sv =====
// Middle stages: energy sum, its square, and the clamped mass radicand.
// Depends on iam_pkg.
module iam_combine #(
  parameter int MB = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_v,
  input  logic [iam_pkg::energy_width(MB)-1:0]  e1,
  input  logic [iam_pkg::energy_width(MB)-1:0]  e2,
  input  logic [2*MB+1:0]                       p2,
  output logic                                  out_v,
  output logic [2*iam_pkg::energy_width(MB)+1:0] rad,
  output logic                                  clamped
);
  import iam_pkg::*;
  localparam int EW = energy_width(MB);
  localparam int FW = 2 * EW + 2;

  logic          va_r, vb_r, vc_r;
  logic [EW:0]   esum_r;
  logic [2*MB+1:0] p2a_r, p2b_r;
  logic [FW-1:0] esq_r;
  logic [FW-1:0] rad_r;
  logic          clamp_r;
  logic [FW:0]   diff;

  assign diff = {1'b0, esq_r} - {1'b0, FW'(p2b_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_v;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      esum_r  <= (EW+1)'(e1) + (EW+1)'(e2);
      p2a_r   <= p2;
      esq_r   <= FW'(esum_r) * FW'(esum_r);
      p2b_r   <= p2a_r;
      rad_r   <= diff[FW] ? '0 : diff[FW-1:0];
      clamp_r <= diff[FW];
    end
  end

  assign out_v   = vc_r;
  assign rad     = rad_r;
  assign clamped = clamp_r;
endmodule

// ===== design/two_body_invariant_mass_core.sv =====
// Channel    Dir  Handshake      Beat contents
// in_ch      in   valid/ready    two masses and two momentum triples
// out_ch     out  valid/ready    pair_mass, radicand_clamped
//
// One beat enters per cycle while the output is not stalled; the three root
// pipelines each resolve one root bit per register stage.
// Synchronous active-low reset clears all valid bits.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Depends on iam_pkg, iam_if, iam_prep, iam_sqrt_pipe, iam_combine.
module two_body_invariant_mass_core #(
  parameter int MOMENTUM_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  iam_in_if.sink    in_ch,
  iam_out_if.source out_ch
);
  import iam_pkg::*;
  localparam int MB  = MOMENTUM_BITS;
  localparam int EW  = energy_width(MB);
  localparam int RW1 = 2 * EW;
  localparam int FW  = 2 * EW + 2;
  localparam int RTW = EW + 1;
  localparam int XW  = (RTW > OUT_BITS) ? RTW : OUT_BITS;

  logic                   en;
  logic signed [MB-1:0]   mom [6];
  logic                   pv;
  logic [RW1-1:0]         rad1, rad2;
  logic [2*MB+1:0]        p2;
  logic                   ev1, ev2;
  logic [EW-1:0]          e1, e2;
  logic [2*MB+1:0]        p2e;
  logic                   cv;
  logic [FW-1:0]          crad;
  logic                   cclamp;
  logic                   rv;
  logic [RTW-1:0]         root;
  logic [XW-1:0]          root_x;
  logic                   rclamp;

  assign en          = !rv || out_ch.ready;
  assign in_ch.ready = en;

  assign mom[0] = in_ch.first_px;
  assign mom[1] = in_ch.first_py;
  assign mom[2] = in_ch.first_pz;
  assign mom[3] = in_ch.second_px;
  assign mom[4] = in_ch.second_py;
  assign mom[5] = in_ch.second_pz;

  iam_prep #(.MB(MB)) u_prep (
    .clk, .rst_n, .en,
    .in_v  (in_ch.valid),
    .m1    (in_ch.first_mass),
    .m2    (in_ch.second_mass),
    .mom   (mom),
    .out_v (pv),
    .rad1  (rad1),
    .rad2  (rad2),
    .p2    (p2)
  );

  iam_sqrt_pipe #(.RW(RW1), .SW(2*MB+2)) u_e1 (
    .clk, .rst_n, .en,
    .in_v     (pv),
    .in_rad   (rad1),
    .in_side  (p2),
    .out_v    (ev1),
    .out_root (e1),
    .out_side (p2e)
  );

  iam_sqrt_pipe #(.RW(RW1), .SW(1)) u_e2 (
    .clk, .rst_n, .en,
    .in_v     (pv),
    .in_rad   (rad2),
    .in_side  (1'b0),
    .out_v    (ev2),
    .out_root (e2),
    .out_side ()
  );

  iam_combine #(.MB(MB)) u_comb (
    .clk, .rst_n, .en,
    .in_v    (ev1 && ev2),
    .e1      (e1),
    .e2      (e2),
    .p2      (p2e),
    .out_v   (cv),
    .rad     (crad),
    .clamped (cclamp)
  );

  iam_sqrt_pipe #(.RW(FW), .SW(1)) u_mass (
    .clk, .rst_n, .en,
    .in_v     (cv),
    .in_rad   (crad),
    .in_side  (cclamp),
    .out_v    (rv),
    .out_root (root),
    .out_side (rclamp)
  );

  assign root_x                  = XW'(root);
  assign out_ch.valid            = rv;
  assign out_ch.pair_mass        = (root_x > XW'(OUT_MAX)) ? OUT_MAX : root_x[OUT_BITS-1:0];
  assign out_ch.radicand_clamped = rclamp;
endmodule

// ===== bench/tb_two_body_invariant_mass_core.sv =====
// Testbench for two_body_invariant_mass_core: drives particle pair beats, predicts
// each pair mass with a wide-integer model and checks every output beat in order.
// Depends on iam_pkg, iam_if and the core.
module tb_two_body_invariant_mass_core;
  import iam_pkg::*;

  localparam int MB = 24;

  typedef struct packed {
    logic [OUT_BITS-1:0] pair_mass;
    logic                radicand_clamped;
  } mass_beat_t;

  logic clk;
  logic rst_n;
  int   fail_cnt;
  bit   sending_done;

  iam_in_if #(.MOMENTUM_BITS(MB)) in_ch ();
  iam_out_if                      out_ch ();

  two_body_invariant_mass_core #(.MOMENTUM_BITS(MB)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  mass_beat_t expected_masses[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] isqrt128(input logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      sq = 128'(t) * 128'(t);
      if (sq <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [127:0] sq_mag(input logic signed [63:0] v);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    return 128'(m) * 128'(m);
  endfunction

  function automatic mass_beat_t predict_pair_mass(
      input logic [MASS_BITS-1:0] m1, input logic signed [MB-1:0] ax, ay, az,
      input logic [MASS_BITS-1:0] m2, input logic signed [MB-1:0] bx, by, bz);
    logic [63:0]  e1;
    logic [63:0]  e2;
    logic [127:0] esq;
    logic [127:0] psq;
    logic [63:0]  root;
    mass_beat_t   res;
    e1 = isqrt128(128'(m1) * 128'(m1) + sq_mag(64'(ax)) + sq_mag(64'(ay)) + sq_mag(64'(az)));
    e2 = isqrt128(128'(m2) * 128'(m2) + sq_mag(64'(bx)) + sq_mag(64'(by)) + sq_mag(64'(bz)));
    esq = 128'(e1 + e2) * 128'(e1 + e2);
    psq = sq_mag(64'(ax) + 64'(bx)) + sq_mag(64'(ay) + 64'(by)) + sq_mag(64'(az) + 64'(bz));
    root = '0;
    res.radicand_clamped = 1'b0;
    if (psq <= esq) root = isqrt128(esq - psq);
    else res.radicand_clamped = 1'b1;
    res.pair_mass = (root > 64'(OUT_MAX)) ? OUT_MAX : root[OUT_BITS-1:0];
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_pair(input logic [MASS_BITS-1:0] m1, input logic [MB-1:0] ax, ay, az,
                           input logic [MASS_BITS-1:0] m2, input logic [MB-1:0] bx, by, bz);
    int idle;
    in_ch.valid       <= 1'b1;
    in_ch.first_mass  <= m1;
    in_ch.first_px    <= ax;
    in_ch.first_py    <= ay;
    in_ch.first_pz    <= az;
    in_ch.second_mass <= m2;
    in_ch.second_px   <= bx;
    in_ch.second_py   <= by;
    in_ch.second_pz   <= bz;
    do @(posedge clk); while (!in_ch.ready);
    expected_masses.push_back(predict_pair_mass(m1, ax, ay, az, m2, bx, by, bz));
    idle = gap_len();
    if (idle != 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  initial begin
    mass_beat_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_masses.size() == 0) begin
          $error("unexpected beat: pair_mass %0d", out_ch.pair_mass);
          fail_cnt++;
        end else begin
          want = expected_masses.pop_front();
          if (out_ch.pair_mass !== want.pair_mass) begin
            $error("pair_mass expected %0d actual %0d", want.pair_mass, out_ch.pair_mass);
            fail_cnt++;
          end
          if (out_ch.radicand_clamped !== want.radicand_clamped) begin
            $error("radicand_clamped expected %0d actual %0d",
                   want.radicand_clamped, out_ch.radicand_clamped);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) < 3 && !sending_done) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic test_extremes();
    logic [MB-1:0] pmax;
    logic [MB-1:0] pmin;
    pmax = {1'b0, {(MB-1){1'b1}}};
    pmin = {1'b1, {(MB-1){1'b0}}};
    send_pair('0, '0, '0, '0, '0, '0, '0, '0);
    send_pair('1, '0, '0, '0, '1, '0, '0, '0);
    send_pair('1, pmax, pmax, pmax, '1, pmax, pmax, pmax);
    send_pair('1, pmin, pmin, pmin, '1, pmin, pmin, pmin);
    send_pair('0, pmax, pmin, pmax, '0, pmin, pmax, pmin);
    send_pair('0, pmin, pmin, pmin, '0, pmax, pmax, pmax);
    send_pair('1, pmin, '0, pmax, '0, '1, pmax, '0);
    send_pair(23'd65536, '0, '0, '0, 23'd65536, '0, '0, '0);
    send_pair(23'd1, '1, '0, '0, 23'd1, 24'd1, '0, '0);
  endtask

  task automatic test_clamp_cases();
    logic [MB-1:0] p;
    // massless collinear pairs: truncated energies tend to drive the radicand negative
    for (int i = 0; i < 14; i++) begin
      p = MB'($urandom_range(1, 8388607));
      send_pair('0, p, MB'($urandom_range(0, 3)), '0, '0, p, MB'($urandom_range(0, 3)), '0);
    end
  endtask

  task automatic test_random_pairs();
    logic [MB-1:0] f [6];
    logic [MASS_BITS-1:0] m1;
    logic [MASS_BITS-1:0] m2;
    int mode;
    for (int n = 0; n < 1750; n++) begin
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 6; k++) begin
        case (mode)
          0: f[k] = MB'($urandom);
          1: f[k] = MB'($signed($urandom_range(0, 2000)) - 1000);
          default: f[k] = MB'($urandom) >>> $urandom_range(0, 20);
        endcase
      end
      m1 = (mode == 1) ? MASS_BITS'($urandom_range(0, 3)) : MASS_BITS'($urandom);
      m2 = ($urandom_range(0, 4) == 0) ? '0 : MASS_BITS'($urandom) >> $urandom_range(0, 22);
      if (mode == 3) begin
        m1 = '0;
        m2 = '0;
        f[3] = f[0];
        f[4] = f[1];
        f[5] = f[2];
      end
      send_pair(m1, f[0], f[1], f[2], m2, f[3], f[4], f[5]);
    end
  endtask

  initial begin
    int waited;
    fail_cnt = 0;
    sending_done = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_mass = '0;
    in_ch.first_px = '0;
    in_ch.first_py = '0;
    in_ch.first_pz = '0;
    in_ch.second_mass = '0;
    in_ch.second_px = '0;
    in_ch.second_py = '0;
    in_ch.second_pz = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_clamp_cases();
    test_random_pairs();
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
    waited = 0;
    while (expected_masses.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (120) @(posedge clk);
    if (fail_cnt == 0 && expected_masses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/iam_pkg.sv
design/iam_if.sv
design/iam_sqrt_pipe.sv
design/iam_prep.sv
design/iam_combine.sv
design/two_body_invariant_mass_core.sv
bench/tb_two_body_invariant_mass_core.sv
